// ===== rtl/osr_pkg.sv =====
package osr_pkg;

  // list geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int FUNC_W  = 2;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int STAT_W  = 2;
  localparam int FOUND_W = 4;
  localparam int FILL_W  = 5;

  // width used to compare a position against the count
  localparam int CMP_W = CNT_W + POS_W;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  // per-cell control
  typedef struct packed {
    logic active; // cell index is below the fill count
    logic load;   // take the appended value
    logic shift;  // take the neighbor's entry
  } cell_ctrl_t;

endpackage

// ===== rtl/osr_cell.sv =====
module osr_cell (
  input  logic                                clk,
  input  osr_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [osr_pkg::VALUE_W-1:0]  append_data,
  input  logic signed [osr_pkg::VALUE_W-1:0]  next_data,
  input  logic signed [osr_pkg::VALUE_W-1:0]  key,
  output logic signed [osr_pkg::VALUE_W-1:0]  entry,
  output logic                                match
);

  logic signed [osr_pkg::VALUE_W-1:0] entry_r;
  logic signed [osr_pkg::VALUE_W-1:0] entry_nxt;

  always_comb begin
    priority if (ctrl.shift) begin
      entry_nxt = next_data;
    end else if (ctrl.load) begin
      entry_nxt = append_data;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = ctrl.active && (entry_r == key);

endmodule

// ===== rtl/osr_lowest.sv =====
module osr_lowest (
  input  logic [osr_pkg::DEPTH-1:0] hits,
  output logic                      any_hit,
  output logic [osr_pkg::IDX_W-1:0] index
);

  always_comb begin
    index = '0;
    for (int i = osr_pkg::DEPTH - 1; i >= 0; i--) begin
      if (hits[i]) begin
        index = osr_pkg::IDX_W'(i);
      end
    end
  end

  assign any_hit = |hits;

endmodule

// ===== rtl/ordered_list_search_remove.sv =====
// Ordered list with linear search and removal by index.
// Input channel (in_valid/in_ready) carries one request: in_func selects
// append (store in_value after the last entry), search (lowest index whose
// entry equals in_value) or remove (delete entry in_position, later entries
// move down one place). Result channel (out_valid/out_ready) returns one
// response per request: out_status, out_found_index, out_fill_count.
// The entries live in a row of cells; in the same cycle every active cell
// compares against the key and, on a remove, each cell at or above
// in_position copies its upper neighbor, so a new request is accepted every
// cycle while the output register is free. out_valid rises the cycle after acceptance.
// The result sits in an output register: while it waits, in_ready stays
// high only if out_ready is high in the same cycle, so a stalled receiver
// holds the input side with no request lost.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result. Entries themselves are not cleared; only entries below the fill
// count are ever read.
module ordered_list_search_remove (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [osr_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [osr_pkg::VALUE_W-1:0] in_value,
  input  logic [osr_pkg::POS_W-1:0]          in_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [osr_pkg::STAT_W-1:0]         out_status,
  output logic [osr_pkg::FOUND_W-1:0]        out_found_index,
  output logic [osr_pkg::FILL_W-1:0]         out_fill_count
);

  localparam int D = osr_pkg::DEPTH;

  logic                        fire;
  logic [osr_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [osr_pkg::STAT_W-1:0]  status_r, status_nxt;
  logic [osr_pkg::IDX_W-1:0]   index_r, index_nxt;

  logic signed [osr_pkg::VALUE_W-1:0] entry [D];
  logic [D-1:0]                       hits;
  osr_pkg::cell_ctrl_t                ctrl [D];
  logic                               any_hit;
  logic [osr_pkg::IDX_W-1:0]          hit_index;

  logic is_append, is_remove, full, pos_ok;

  // handshake: output register frees up when the receiver takes it
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  assign is_append = (in_func == osr_pkg::FUNC_APPEND);
  assign is_remove = (in_func == osr_pkg::FUNC_REMOVE);
  assign full      = (count_r == osr_pkg::CNT_W'(D));
  assign pos_ok    = osr_pkg::CMP_W'(in_position) < osr_pkg::CMP_W'(count_r);

  // cell row; cell i copies cell i+1 on a remove at or below i
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic signed [osr_pkg::VALUE_W-1:0] next_data;

    if (i == D - 1) begin : g_last
      assign next_data = entry[i];
    end else begin : g_mid
      assign next_data = entry[i+1];
    end

    assign ctrl[i].active = osr_pkg::CNT_W'(i) < count_r;
    assign ctrl[i].load   = fire && is_append && !full &&
                            (osr_pkg::CNT_W'(i) == count_r);
    assign ctrl[i].shift  = fire && is_remove && pos_ok &&
                            (osr_pkg::CMP_W'(i) >= osr_pkg::CMP_W'(in_position));

    osr_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl[i]),
      .append_data (in_value),
      .next_data   (next_data),
      .key         (in_value),
      .entry       (entry[i]),
      .match       (hits[i])
    );
  end

  osr_lowest u_lowest (
    .hits    (hits),
    .any_hit (any_hit),
    .index   (hit_index)
  );

  // response and count update
  always_comb begin
    count_nxt     = count_r;
    status_nxt    = status_r;
    index_nxt     = index_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (fire) begin
      out_valid_nxt = 1'b1;
      index_nxt     = '0;
      unique case (in_func)
        osr_pkg::FUNC_APPEND: begin
          if (full) begin
            status_nxt = osr_pkg::ST_FULL;
          end else begin
            status_nxt = osr_pkg::ST_OK;
            count_nxt  = count_r + 1'b1;
          end
        end
        osr_pkg::FUNC_SEARCH: begin
          if (any_hit) begin
            status_nxt = osr_pkg::ST_OK;
            index_nxt  = hit_index;
          end else begin
            status_nxt = osr_pkg::ST_NOT_FOUND;
          end
        end
        osr_pkg::FUNC_REMOVE: begin
          if (pos_ok) begin
            status_nxt = osr_pkg::ST_OK;
            count_nxt  = count_r - 1'b1;
          end else begin
            status_nxt = osr_pkg::ST_BAD_INDEX;
          end
        end
        osr_pkg::FUNC_UNUSED: begin
          status_nxt = osr_pkg::ST_BAD_INDEX;
        end
        default: begin
          status_nxt = osr_pkg::ST_BAD_INDEX;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    index_r  <= index_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_index = osr_pkg::FOUND_W'(index_r);
  assign out_fill_count  = osr_pkg::FILL_W'(count_r);

  // fill count never passes the list depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= osr_pkg::CNT_W'(D))
    else $error("fill count above depth");

  // a successful append grows the list by one
  a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_append && !full |=> count_r == $past(count_r) + 1'b1)
    else $error("append did not grow list");

  // a successful remove shrinks the list by one
  a_remove_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_remove && pos_ok |=> count_r == $past(count_r) - 1'b1)
    else $error("remove did not shrink list");

  // only a successful search reports a nonzero index
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != osr_pkg::ST_OK |-> index_r == '0)
    else $error("index set on failed request");

  // input side is held only by a waiting response
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r)
    else $error("input stalled with no pending response");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// Checks ordered_list_search_remove against a cycle-free predictor of the list.
// Requests go in on in_*, and each accepted request pushes its predicted response
// onto a queue. Responses on out_* are compared in order, one field at a time.
module testbench;

  localparam int CYCLE_LIMIT = 200_000;

  typedef struct packed {
    logic [osr_pkg::STAT_W-1:0]  status;
    logic [osr_pkg::FOUND_W-1:0] found_index;
    logic [osr_pkg::FILL_W-1:0]  fill_count;
  } list_result_t;

  // DUT ports; every input is known from time zero
  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [osr_pkg::FUNC_W-1:0]         in_func = osr_pkg::FUNC_APPEND;
  logic signed [osr_pkg::VALUE_W-1:0] in_value = '0;
  logic [osr_pkg::POS_W-1:0]          in_position = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [osr_pkg::STAT_W-1:0]         out_status;
  logic [osr_pkg::FOUND_W-1:0]        out_found_index;
  logic [osr_pkg::FILL_W-1:0]         out_fill_count;

  // predictor state: a copy of the list as the DUT should hold it
  logic [osr_pkg::VALUE_W-1:0] list_mem [osr_pkg::DEPTH];
  int                          list_count = 0;

  list_result_t pending_results [$];
  int           fail_count = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;

  ordered_list_search_remove u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_fill_count  (out_fill_count)
  );

  always #1 clk = ~clk;

  // Apply one request to the shadow list and return the response it must produce.
  // Search scans downward so the last hit kept is the lowest index.
  function automatic list_result_t apply_list_op(logic [osr_pkg::FUNC_W-1:0] op,
                                                 logic [osr_pkg::VALUE_W-1:0] key,
                                                 logic [osr_pkg::POS_W-1:0] pos);
    list_result_t res;
    int           i;
    res.status      = osr_pkg::ST_OK;
    res.found_index = '0;
    case (op)
      osr_pkg::FUNC_APPEND: begin
        if (list_count >= osr_pkg::DEPTH) begin
          res.status = osr_pkg::ST_FULL;            // dropped, list untouched
        end else begin
          list_mem[list_count] = key;
          list_count++;
        end
      end
      osr_pkg::FUNC_SEARCH: begin
        res.status = osr_pkg::ST_NOT_FOUND;
        for (i = list_count - 1; i >= 0; i--) begin
          if (list_mem[i] == key) begin
            res.status      = osr_pkg::ST_OK;
            res.found_index = i[osr_pkg::FOUND_W-1:0];
          end
        end
      end
      osr_pkg::FUNC_REMOVE: begin
        if (int'(pos) >= list_count) begin
          res.status = osr_pkg::ST_BAD_INDEX;       // beyond fill count: no change
        end else begin
          for (i = int'(pos); i + 1 < list_count; i++) list_mem[i] = list_mem[i + 1];
          list_count--;
        end
      end
      default: res.status = osr_pkg::ST_BAD_INDEX;  // unused code: no change
    endcase
    res.fill_count = list_count[osr_pkg::FILL_W-1:0];
    return res;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $time, msg);
  endtask

  // Monitor: predict on request acceptance first, then check any response
  // taken at the same edge, so a response taken in the same cycle as its request would still line up.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        pending_results.push_back(apply_list_op(in_func, in_value, in_position));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          note_failure($sformatf("response with none pending: status %0d idx %0d fill %0d",
                                 out_status, out_found_index, out_fill_count));
        end else begin
          want = pending_results.pop_front();
          if (want.status != out_status || want.found_index != out_found_index ||
              want.fill_count != out_fill_count)
            note_failure($sformatf("exp status %0d idx %0d fill %0d, got %0d %0d %0d",
                                   want.status, want.found_index, want.fill_count,
                                   out_status, out_found_index, out_fill_count));
        end
      end
    end
  end

  // receiver backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance with
  // in_valid still high, so back-to-back requests never drop valid.
  task automatic send_request(logic [osr_pkg::FUNC_W-1:0] op,
                              logic [osr_pkg::VALUE_W-1:0] key,
                              logic [osr_pkg::POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= op;
    in_value    <= key;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // hold off the sender until every response is back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_list();
    send_request(osr_pkg::FUNC_SEARCH, 32'h0000_0000, 8'd0);   // nothing to match
    send_request(osr_pkg::FUNC_REMOVE, 32'h0000_0000, 8'd0);   // index 0 invalid when empty
    send_request(osr_pkg::FUNC_UNUSED, 32'hffff_ffff, 8'hff);  // unused code
  endtask

  task automatic test_fill_to_capacity();
    int i;
    send_request(osr_pkg::FUNC_APPEND, 32'h8000_0000, 8'd0);
    send_request(osr_pkg::FUNC_APPEND, 32'h7fff_ffff, 8'd0);
    send_request(osr_pkg::FUNC_APPEND, 32'hffff_ffff, 8'd0);
    send_request(osr_pkg::FUNC_APPEND, 32'h0000_0000, 8'd0);
    send_request(osr_pkg::FUNC_APPEND, 32'h0000_0005, 8'd0);
    send_request(osr_pkg::FUNC_APPEND, 32'h8000_0000, 8'd0);   // duplicate of entry 0
    for (i = 6; i < osr_pkg::DEPTH; i++)
      send_request(osr_pkg::FUNC_APPEND, 32'h5a5a_0000 | i, 8'd0);
    send_request(osr_pkg::FUNC_SEARCH, 32'h5a5a_000f, 8'd0);   // hit in the top slot
    send_request(osr_pkg::FUNC_SEARCH, 32'h8000_0000, 8'd0);   // lowest of two matches
    send_request(osr_pkg::FUNC_APPEND, 32'h1234_5678, 8'd0);   // list full
    send_request(osr_pkg::FUNC_SEARCH, 32'h1234_5678, 8'd0);   // dropped value absent
  endtask

  task automatic test_remove_cases();
    send_request(osr_pkg::FUNC_REMOVE, 32'h0, 8'hff);          // far out of range
    send_request(osr_pkg::FUNC_REMOVE, 32'h0,
                 osr_pkg::POS_W'(osr_pkg::DEPTH));             // exactly at fill count
    send_request(osr_pkg::FUNC_REMOVE, 32'h0, 8'd0);           // head, everything shifts
    send_request(osr_pkg::FUNC_SEARCH, 32'h8000_0000, 8'd0);   // duplicate moved down
    send_request(osr_pkg::FUNC_REMOVE, 32'h0,
                 osr_pkg::POS_W'(osr_pkg::DEPTH - 2));         // last entry
  endtask

  function automatic logic [osr_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(3))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom_range(7);              // small keys -> duplicates
    endcase
  endfunction

  // Mostly well-formed traffic: searches for stored keys, removes within range.
  // A share of misses, bad indexes and unused codes keeps the error paths busy.
  task automatic test_random_traffic(int n_reqs, int send_pct, int recv_pct);
    int                          i;
    int                          r;
    logic [osr_pkg::FUNC_W-1:0]  op;
    logic [osr_pkg::VALUE_W-1:0] key;
    logic [osr_pkg::POS_W-1:0]   pos;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (i = 0; i < n_reqs; i++) begin
      if (i == n_reqs / 2) wait_for_drain();
      r   = $urandom_range(99);
      key = pick_value();
      pos = osr_pkg::POS_W'($urandom_range(255));
      if (r < 36) begin
        op = osr_pkg::FUNC_APPEND;
      end else if (r < 68) begin
        op = osr_pkg::FUNC_SEARCH;
        if (list_count > 0 && $urandom_range(9) < 7)
          key = list_mem[osr_pkg::IDX_W'($urandom_range(list_count - 1))];
      end else if (r < 96) begin
        op = osr_pkg::FUNC_REMOVE;
        if (list_count > 0 && $urandom_range(3) != 0)
          pos = osr_pkg::POS_W'($urandom_range(list_count - 1));
      end else begin
        op = osr_pkg::FUNC_UNUSED;
      end
      send_request(op, key, pos);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_fill_to_capacity();
    test_remove_cases();
    test_random_traffic(134, 18, 86);
    test_random_traffic(133, 86, 18);
    test_random_traffic(133, 0, 0);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);  // catch any stray response
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== ordered_list_search_remove.f =====
rtl/osr_pkg.sv
rtl/osr_cell.sv
rtl/osr_lowest.sv
rtl/ordered_list_search_remove.sv
test/testbench.sv
